// File: sv/ffca_pkg.sv
// shared types and constants of the first-fit contiguous allocator
package ffca_pkg;

    // default number of built slots
    localparam int HALL_SLOTS_DEF = 64;

    // item and result field widths
    localparam int MODE_W  = 1;
    localparam int START_W = 6;
    localparam int WIDTH_W = 7;
    localparam int HALL_W  = 7;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_HALL_SIZE = 1'b0;
    localparam logic [HALL_W-1:0] HALL_SIZE_RST = 7'd64;

    // item kinds
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear_step;
        logic scan_step;
        logic walk_step;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic scan_hit;
        logic scan_miss;
        logic walk_done;
        logic out_busy;
    } dp_sts_t;

endpackage

// File: sv/ffca_ram.sv
// generic single-write, single-read ram with registered read data
module ffca_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/ffca_datapath.sv
// datapath: occupancy map, scan and walk counters, output register
module ffca_datapath
    import ffca_pkg::*;
#(
    parameter int HALL_SLOTS = HALL_SLOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_sts_t             sts,
    input  logic [HALL_W-1:0]   hall_size,
    input  logic                s_mode,
    input  logic [START_W-1:0]  s_start,
    input  logic [WIDTH_W-1:0]  s_width,
    input  logic                m_tready,
    output logic                m_valid,
    output logic                m_granted,
    output logic [START_W-1:0]  m_start
);

    localparam int IDX_W = (HALL_SLOTS > 1) ? $clog2(HALL_SLOTS) : 1;
    localparam int CNT_W = $clog2(HALL_SLOTS + 1);
    localparam int SZ_W  = ((CNT_W > WIDTH_W) ? CNT_W : WIDTH_W) + 1;

    logic [SZ_W-1:0]    idx_reg;
    logic [SZ_W-1:0]    end_reg;
    logic [SZ_W-1:0]    size_reg;
    logic [SZ_W-1:0]    width_reg;
    logic [SZ_W-1:0]    run_reg;
    logic [IDX_W-1:0]   first_reg;
    logic [IDX_W-1:0]   ev_idx_reg;
    logic               ev_vld_reg;
    logic               mode_reg;
    logic               grant_reg;
    logic [START_W-1:0] res_reg;
    logic               m_valid_reg;
    logic               m_granted_reg;
    logic [START_W-1:0] m_start_reg;

    logic [SZ_W-1:0]    eff_size;
    logic [SZ_W-1:0]    free_sum;
    logic [SZ_W-1:0]    free_end;
    logic [SZ_W-1:0]    run_inc;
    logic [IDX_W-1:0]   first_new;
    logic               ev_busy;
    logic               hit;
    logic               miss;
    logic               ram_we;
    logic               ram_wdata;

    // hall size clipped at the built count
    assign eff_size = (SZ_W'(hall_size) >= SZ_W'(HALL_SLOTS)) ? SZ_W'(HALL_SLOTS)
                                                               : SZ_W'(hall_size);
    assign free_sum = SZ_W'(s_start) + SZ_W'(s_width);
    assign free_end = (free_sum > eff_size) ? eff_size : free_sum;

    // scan evaluation of the slot read in the previous cycle
    assign run_inc   = run_reg + SZ_W'(1);
    assign first_new = (run_reg == '0) ? ev_idx_reg : first_reg;
    assign hit       = ev_vld_reg && !ev_busy && (run_inc == width_reg);
    assign miss      = (width_reg == '0) || (!ev_vld_reg && (idx_reg >= size_reg));

    assign ram_we    = cmd.clear_step || cmd.walk_step;
    assign ram_wdata = cmd.clear_step ? 1'b0 : (mode_reg == MODE_ALLOC);

    ffca_ram #(
        .WIDTH (1),
        .DEPTH (HALL_SLOTS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ev_busy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            ev_vld_reg <= 1'b0;
        end else if (cmd.load) begin
            mode_reg   <= s_mode;
            width_reg  <= SZ_W'(s_width);
            size_reg   <= eff_size;
            run_reg    <= '0;
            first_reg  <= '0;
            ev_vld_reg <= 1'b0;
            if (s_mode == MODE_FREE) begin
                idx_reg   <= SZ_W'(s_start);
                end_reg   <= free_end;
                grant_reg <= 1'b1;
                res_reg   <= s_start;
            end else begin
                idx_reg   <= '0;
                grant_reg <= 1'b0;
                res_reg   <= '0;
            end
        end else if (cmd.clear_step || cmd.walk_step) begin
            idx_reg <= idx_reg + SZ_W'(1);
        end else if (cmd.scan_step) begin
            if (hit) begin
                idx_reg    <= SZ_W'(first_new);
                end_reg    <= SZ_W'(first_new) + width_reg;
                grant_reg  <= 1'b1;
                res_reg    <= START_W'(first_new);
                ev_vld_reg <= 1'b0;
            end else begin
                if (ev_vld_reg) begin
                    run_reg <= ev_busy ? '0 : run_inc;
                    if (!ev_busy) begin
                        first_reg <= first_new;
                    end
                end
                if (idx_reg < size_reg) begin
                    idx_reg    <= idx_reg + SZ_W'(1);
                    ev_idx_reg <= idx_reg[IDX_W-1:0];
                    ev_vld_reg <= 1'b1;
                end else begin
                    ev_vld_reg <= 1'b0;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg   <= 1'b1;
            m_granted_reg <= grant_reg;
            m_start_reg   <= res_reg;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_granted = m_granted_reg;
    assign m_start   = m_start_reg;

    assign sts.clr_last  = (idx_reg == SZ_W'(HALL_SLOTS - 1));
    assign sts.scan_hit  = hit;
    assign sts.scan_miss = miss;
    assign sts.walk_done = (idx_reg >= end_reg);
    assign sts.out_busy  = m_valid_reg && !m_tready;

endmodule

// File: sv/ffca_ctrl.sv
// controller state machine: clearing pass, scan, run update, result hand-off
module ffca_ctrl
    import ffca_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  logic    s_mode,
    output logic    s_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WALK,
        ST_RESP
    } state_t;

    state_t state_reg;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd            = '0;
        cmd.load       = accept;
        cmd.clear_step = (state_reg == ST_CLEAR);
        cmd.scan_step  = (state_reg == ST_SCAN);
        cmd.walk_step  = (state_reg == ST_WALK) && !sts.walk_done;
        cmd.out_load   = (state_reg == ST_RESP) && !sts.out_busy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    if (sts.clr_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= (s_mode == MODE_FREE) ? ST_WALK : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (sts.scan_hit) begin
                        state_reg <= ST_WALK;
                    end else if (sts.scan_miss) begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_WALK: begin
                    if (sts.walk_done) begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_RESP: begin
                    if (!sts.out_busy) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

endmodule

// File: sv/first_fit_contiguous_allocator.sv
// top level: first-fit contiguous slot allocator with apb configuration
// throughput: one item at a time; the map ram is scanned one slot per cycle
// reset: synchronous active-low aresetn; afterwards a clearing pass marks every one of the
//   HALL_SLOTS slots free, and s_tready stays low until it ends
// hall_size resets to 64; configuration writes are taken at any time
module first_fit_contiguous_allocator
    import ffca_pkg::*;
#(
    parameter int HALL_SLOTS = HALL_SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // run_start[5:0], run_width[12:6], zero pad
    input  logic [0:0]           s_tuser,   // mode[0]
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // granted[0], start_index[6:1], zero pad
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    logic [HALL_W-1:0]  hall_size_reg;
    logic               cfg_wr;
    dp_cmd_t            dp_cmd;
    dp_sts_t            dp_sts;
    logic               m_granted;
    logic [START_W-1:0] m_start;

    // register write happens on the access phase of a transfer
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hall_size_reg <= HALL_SIZE_RST;
        end else if (cfg_wr && (paddr[2] == REG_HALL_SIZE)) begin
            hall_size_reg <= pwdata[HALL_W-1:0];
        end
    end

    // register index comes from the word address bit; other indexes read zero
    assign prdata = (paddr[2] == REG_HALL_SIZE) ? PDATA_W'(hall_size_reg) : '0;

    // sequencer: clearing pass, scan, mark or free, result hand-off
    ffca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_mode   (s_tuser[0]),
        .s_tready (s_tready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    // map ram, counters, and the output register that lets the next transfer in
    ffca_datapath #(
        .HALL_SLOTS (HALL_SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (dp_cmd),
        .sts       (dp_sts),
        .hall_size (hall_size_reg),
        .s_mode    (s_tuser[0]),
        .s_start   (s_tdata[START_W-1:0]),
        .s_width   (s_tdata[START_W+WIDTH_W-1:START_W]),
        .m_tready  (m_tready),
        .m_valid   (m_tvalid),
        .m_granted (m_granted),
        .m_start   (m_start)
    );

    assign m_tdata = {1'b0, m_start, m_granted};

    // a refused allocation always reports start zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_granted) |-> (m_start == '0))
        else $error("refused allocation with nonzero start");

    // the map is never written while a new transfer can be taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!dp_cmd.walk_step && !dp_cmd.clear_step))
        else $error("map write while idle");

    // a result is only loaded into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwrote a pending transfer");

    // reset always starts the clearing pass
    assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

endmodule

// File: dv/tb_first_fit_contiguous_allocator.sv
// testbench of the first-fit contiguous slot allocator: random and directed streams, self-checked
module tb_first_fit_contiguous_allocator;
    import ffca_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALL_SLOTS = HALL_SLOTS_DEF;
    // longest single item: full scan plus marking of a full-width run, with margin
    localparam int SETTLE_CYCLES = 2 * HALL_SLOTS + 16;
    // run cap: the simulation fails and stops once the cycle count passes it
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES = 8;

    // byte addresses on the configuration port
    localparam logic [PADDR_W-1:0] ADDR_HALL_SIZE = PADDR_W'(4 * REG_HALL_SIZE);
    localparam logic [PADDR_W-1:0] ADDR_NO_REG    = PADDR_W'(4);

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_style_t;

    typedef struct {
        logic               mode;
        logic [START_W-1:0] first_slot;
        logic [WIDTH_W-1:0] run_len;
        bit                 wait_idle;   // hold back until every result is back
    } slot_request_t;

    typedef struct {
        logic               granted;
        logic [START_W-1:0] start_index;
    } slot_grant_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // input stream
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // run_start[5:0], run_width[12:6], zero pad
    logic [0:0]          s_tuser  = '0;   // mode[0]

    // result stream
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // granted[0], start_index[6:1], zero pad

    // configuration port
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // testbench copy of the allocator state
    logic [HALL_SLOTS-1:0] slot_map = '0;
    logic [HALL_W-1:0]     hall_cfg = HALL_SIZE_RST;

    slot_request_t request_q[$];       // transfers not yet offered
    slot_grant_t   awaited_grants[$];  // predicted results in order
    idle_style_t   idle_style = IDLE_NONE;
    logic          in_taken   = 1'b0;  // input transfer seen at the last rising edge

    int mismatches    = 0;
    int cycle_count   = 0;
    int alloc_count   = 0;
    int granted_count = 0;
    int free_count    = 0;
    int hall_writes   = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    first_fit_contiguous_allocator #(
        .HALL_SLOTS(HALL_SLOTS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // first-fit behavior on the local map: frees clip at the hall, allocations
    // take the lowest run of free slots that lies wholly inside the hall
    function automatic slot_grant_t apply_to_map(input logic mode,
                                                 input logic [START_W-1:0] first_slot,
                                                 input logic [WIDTH_W-1:0] run_len);
        slot_grant_t res;
        int          hall_len;
        int          run;
        int          lead;
        hall_len = (hall_cfg < HALL_SLOTS) ? int'(hall_cfg) : HALL_SLOTS;
        res.granted = 1'b0;
        res.start_index = '0;
        if (mode == MODE_FREE) begin
            for (int i = int'(first_slot); i < int'(first_slot) + int'(run_len) && i < hall_len;
                 i++) begin
                slot_map[i] = 1'b0;
            end
            res.granted = 1'b1;
            res.start_index = first_slot;
            return res;
        end
        // zero width never grants
        if (run_len == 0) begin
            return res;
        end
        run = 0;
        lead = 0;
        for (int i = 0; i < hall_len; i++) begin
            if (!slot_map[i]) begin
                if (run == 0) begin
                    lead = i;
                end
                run++;
            end else begin
                run = 0;
            end
            if (run == int'(run_len)) begin
                for (int k = lead; k < lead + int'(run_len); k++) begin
                    slot_map[k] = 1'b1;
                end
                res.granted = 1'b1;
                res.start_index = START_W'(lead);
                return res;
            end
        end
        return res;
    endfunction

    function automatic void flag_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        end
    endfunction

    function automatic void queue_request(input logic mode, input int first_slot,
                                          input int run_len, input bit wait_idle);
        slot_request_t req;
        req.mode = mode;
        req.first_slot = START_W'(first_slot);
        req.run_len = WIDTH_W'(run_len);
        req.wait_idle = wait_idle;
        request_q.push_back(req);
    endfunction

    // mostly small allocations and frees near the live area, a little noise
    function automatic void queue_random(input int hall_len);
        int pick;
        int roll;
        int cap;
        int w;
        int s;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            queue_request($urandom_range(0, 1) ? MODE_FREE : MODE_ALLOC,
                          $urandom_range(0, 63), $urandom_range(0, 64), 1'b0);
        end else if (pick < 56) begin
            cap = (hall_len < 8) ? hall_len + 1 : 8;
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                w = 0;
            end else if (roll < 15) begin
                w = $urandom_range(1, (hall_len < 64) ? hall_len + 1 : 64);
            end else begin
                w = $urandom_range(1, cap);
            end
            // run_start is don't-care on allocations, so let it wander
            queue_request(MODE_ALLOC, $urandom_range(0, 63), w, 1'b0);
        end else begin
            s = (hall_len == 0) ? $urandom_range(0, 63) : $urandom_range(0, hall_len - 1);
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 6);
            queue_request(MODE_FREE, s, w, 1'b0);
        end
    endfunction

    // one apb transfer: setup then access, completes on pready
    task automatic apb_transfer(input logic wr, input logic [PADDR_W-1:0] addr,
                                input logic [PDATA_W-1:0] wdata,
                                output logic [PDATA_W-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        rdata = prdata;
        if (wr && addr == ADDR_HALL_SIZE) begin
            hall_cfg = wdata[HALL_W-1:0];
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write the hall size and read it back
    task automatic set_hall(input int value);
        logic [PDATA_W-1:0] rd;
        apb_transfer(1'b1, ADDR_HALL_SIZE, PDATA_W'(value), rd);
        apb_transfer(1'b0, ADDR_HALL_SIZE, '0, rd);
        if (rd !== PDATA_W'(value & 8'h7f)) begin
            flag_mismatch("hall_size readback", value & 8'h7f, int'(rd));
        end
        hall_writes++;
    endtask

    // wait until every queued transfer is done and the block has gone quiet
    task automatic drain_all();
        while (request_q.size() != 0 || s_tvalid || awaited_grants.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d results outstanding",
                     cycle_count, awaited_grants.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // sender: offers the next queued transfer at the falling edge
    always @(negedge aclk) begin
        slot_request_t req;
        bit            sender_idle;
        if (aresetn && (!s_tvalid || in_taken)) begin
            sender_idle = (idle_style == IDLE_SENDER && $urandom_range(0, 99) < 70) ||
                          (idle_style == IDLE_BOTH && $urandom_range(0, 99) < 26);
            if (request_q.size() != 0 && !sender_idle &&
                !(request_q[0].wait_idle && awaited_grants.size() != 0)) begin
                req = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= S_DATA_W'({req.run_len, req.first_slot});
                s_tuser  <= req.mode;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random backpressure per phase
    always @(negedge aclk) begin
        bit stall;
        stall = (idle_style == IDLE_RECEIVER && $urandom_range(0, 99) < 70) ||
                (idle_style == IDLE_BOTH && $urandom_range(0, 99) < 26);
        m_tready <= !stall;
    end

    // monitor: check results first, then predict for an accepted input
    always @(posedge aclk) begin
        slot_grant_t want;
        slot_grant_t seen;
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            seen.granted = m_tdata[0];
            seen.start_index = m_tdata[START_W:1];
            if (awaited_grants.size() == 0) begin
                flag_mismatch("result transfer with none awaited, granted", -1,
                              int'(seen.granted));
            end else begin
                want = awaited_grants.pop_front();
                if (seen.granted !== want.granted) begin
                    flag_mismatch("granted", int'(want.granted), int'(seen.granted));
                end
                if (seen.start_index !== want.start_index) begin
                    flag_mismatch("start_index", int'(want.start_index),
                                  int'(seen.start_index));
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            want = apply_to_map(s_tuser[0], s_tdata[START_W-1:0],
                                s_tdata[START_W+WIDTH_W-1:START_W]);
            awaited_grants.push_back(want);
            if (s_tuser[0] == MODE_FREE) begin
                free_count++;
            end else begin
                alloc_count++;
                if (want.granted) begin
                    granted_count++;
                end
            end
        end
    end

    // stimulus sequence
    initial begin
        int                 hall_seq[PHASES];
        int                 phase_items;
        int                 hall_len;
        logic [PDATA_W-1:0] rd;

        hall_seq = '{17, 100, 1, 0, 127, 40, 64, 9};
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset hall of 64, fresh empty map
        queue_request(MODE_ALLOC, 5, 0, 1'b0);      // zero width refused
        queue_request(MODE_ALLOC, 63, 64, 1'b0);    // whole hall
        queue_request(MODE_ALLOC, 0, 1, 1'b0);      // map full
        queue_request(MODE_FREE, 0, 64, 1'b0);
        queue_request(MODE_ALLOC, 42, 1, 1'b0);
        queue_request(MODE_ALLOC, 0, 3, 1'b0);
        queue_request(MODE_ALLOC, 21, 2, 1'b0);
        queue_request(MODE_FREE, 1, 3, 1'b0);       // opens a three-slot hole
        queue_request(MODE_ALLOC, 7, 4, 1'b0);      // hole too small, goes past it
        queue_request(MODE_ALLOC, 0, 3, 1'b0);      // fills the hole exactly
        queue_request(MODE_FREE, 63, 64, 1'b0);     // clipped at the hall end
        queue_request(MODE_FREE, 4, 0, 1'b0);       // zero-width free
        queue_request(MODE_FREE, 20, 5, 1'b0);      // slots already free
        queue_request(MODE_ALLOC, 0, 64, 1'b0);     // no room left for the whole hall
        queue_request(MODE_FREE, 0, 64, 1'b1);      // also waits for an empty pipe
        queue_request(MODE_ALLOC, 0, 63, 1'b0);
        queue_request(MODE_ALLOC, 0, 2, 1'b0);      // only one slot left
        queue_request(MODE_ALLOC, 0, 1, 1'b0);      // the top slot
        queue_request(MODE_FREE, 0, 64, 1'b0);
        drain_all();

        // an address with no register behind it must leave hall_size alone
        apb_transfer(1'b1, ADDR_NO_REG, PDATA_W'(5), rd);
        apb_transfer(1'b0, ADDR_HALL_SIZE, '0, rd);
        if (rd !== PDATA_W'(hall_cfg)) begin
            flag_mismatch("hall_size after write to unused address", int'(hall_cfg), int'(rd));
        end

        for (int p = 0; p < PHASES; p++) begin
            set_hall(hall_seq[p]);
            idle_style = idle_style_t'(p % 4);
            hall_len = (hall_seq[p] < HALL_SLOTS) ? hall_seq[p] : HALL_SLOTS;
            phase_items = (hall_len == 0) ? 30 : ((hall_len == 1) ? 100 : 170);
            // each phase opens with a clean hall and a request one wider than it, capped at 64 slots
            queue_request(MODE_FREE, 0, 64, 1'b0);
            queue_request(MODE_ALLOC, 0, (hall_len < 64) ? hall_len + 1 : 64, 1'b0);
            queue_request(MODE_FREE, 0, 64, 1'b0);
            if (hall_len > 0) begin
                queue_request(MODE_ALLOC, 0, hall_len, 1'b0);
            end
            // free starting at the hall end clears nothing; with a full hall it frees the top slot
            queue_request(MODE_FREE, (hall_len < 64) ? hall_len : 63, 3, 1'b0);
            for (int n = 0; n < phase_items; n++) begin
                queue_random(hall_len);
                // mid-phase the sender holds off until the pipe is empty
                if (n == phase_items / 2) begin
                    request_q[request_q.size() - 1].wait_idle = 1'b1;
                end
            end
            drain_all();
        end

        $display("covered %0d allocations (%0d granted) and %0d frees", alloc_count,
                 granted_count, free_count);
        $display("over %0d hall_size settings and four idle/backpressure styles", hall_writes);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/ffca_pkg.sv
sv/ffca_ram.sv
sv/ffca_datapath.sv
sv/ffca_ctrl.sv
sv/first_fit_contiguous_allocator.sv
dv/tb_first_fit_contiguous_allocator.sv
